// File: rtl/core/sip_tree_hash_four_lane_top_macros.svh
// assertion helpers
`ifndef SIP_TREE_HASH_FOUR_LANE_TOP_MACROS_SVH
`define SIP_TREE_HASH_FOUR_LANE_TOP_MACROS_SVH
`define STH_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define STH_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// File: rtl/core/sth_pkg.sv
`timescale 1ns / 1ps
package sth_pkg;
  localparam logic [63:0] INIT_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_C3 = 64'h7465646279746573;
  localparam logic [63:0] FINAL_MIX = 64'hFF;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [1:0] CFG_KEY_0 = 2'd0;
  localparam logic [1:0] CFG_KEY_1 = 2'd1;
  localparam logic [1:0] CFG_KEY_2 = 2'd2;
  localparam logic [1:0] CFG_KEY_3 = 2'd3;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] lane_hash_0;
    logic [63:0] lane_hash_1;
    logic [63:0] lane_hash_2;
    logic [63:0] lane_hash_3;
  } out_item_t;

  typedef logic [3:0][63:0] lane_vec_t;

  // one job for the back part: a word for one lane, or close of message
  typedef struct packed {
    logic        load;
    logic [1:0]  lane;
    logic [63:0] msg;
    logic        fin;
  } job_t;

  function automatic lane_vec_t arx_round(lane_vec_t v);
    logic [63:0] a, b, c, d;
    a = v[0] + v[1];
    c = v[2] + v[3];
    b = {v[1][50:0], v[1][63:51]} ^ a;
    d = {v[3][47:0], v[3][63:48]} ^ c;
    a = {a[31:0], a[63:32]};
    c = c + b;
    a = a + d;
    b = {b[46:0], b[63:47]} ^ c;
    d = {d[42:0], d[63:43]} ^ a;
    c = {c[31:0], c[63:32]};
    arx_round = '0;
    arx_round[0] = a;
    arx_round[1] = b;
    arx_round[2] = c;
    arx_round[3] = d;
  endfunction
endpackage

// File: rtl/core/sip_tree_hash_four_lane_top.sv
// flow: an accepted word is written into the job queue, then taken by the back part when it is idle
// and run through the arx rounds; a last word makes 1 to 5 lane jobs, then all four lanes are
// finalised in turn before its item is shown by a low empty
// sharing: the back part takes no new job until it is done with the last one, since the single
// shared arx round unit serves all lanes; a closing job waits until the pending item is popped
// reset: synchronous active-low rst_n clears keys, lane position and queues
`timescale 1ns / 1ps
module sip_tree_hash_four_lane_top #(
  parameter int QDEPTH = sth_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sth_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output sth_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import sth_pkg::*;

  logic [3:0][63:0] keys_r;
  logic  fj_v, fj_r, bj_v, bj_r;
  job_t  fj, bj;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) keys_r <= '0;
    else if (cfg_valid) keys_r[cfg_index - CFG_KEY_0] <= cfg_data;
  end

  sth_front u_front (.clk, .rst_n, .in_push, .in_full, .in_item,
    .job_valid(fj_v), .job_ready(fj_r), .job(fj));

  sth_queue #(.DEPTH(QDEPTH), .W($bits(job_t))) u_q (.clk, .rst_n,
    .wr_valid(fj_v), .wr_ready(fj_r), .wr_data(fj),
    .rd_valid(bj_v), .rd_ready(bj_r), .rd_data(bj));

  sth_back u_back (.clk, .rst_n, .keys(keys_r), .job_valid(bj_v), .job_ready(bj_r),
    .job(bj), .out_empty(empty), .out_pop(pop), .out_item);
endmodule

// File: rtl/core/sth_front.sv
`timescale 1ns / 1ps
module sth_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sth_pkg::in_item_t in_item,
  output logic              job_valid,
  input  logic              job_ready,
  output sth_pkg::job_t     job
);
  import sth_pkg::*;

  typedef enum logic [1:0] {
    F_PASS = 2'b01,
    F_TAIL = 2'b10
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [1:0]  pos_r, pos_nxt, tail_lane_r, tail_lane_nxt;
  logic        open_r, open_nxt;
  logic [63:0] top_r, top_nxt;
  logic        pend_fin_r, pend_fin_nxt;
  logic [3:0]  c;
  logic [2:0]  keep;
  logic [5:0]  r;
  logic [63:0] word, tail, topw, d;
  logic        acc;

  assign d = in_item.data_word;
  assign c = (in_item.byte_count > 4'd8) ? 4'd8 : in_item.byte_count;
  assign keep = {1'b0, c[3:2]};
  assign r = {pos_r, 3'b000} + {2'b00, c};
  assign in_full = (state_r != F_PASS) || !job_ready;
  assign acc = in_push && !in_full;

  always_comb begin
    word = '0;
    tail = '0;
    case (keep)
      3'd0: tail = d;
      3'd1: begin
        word = {32'd0, d[31:0]};
        tail = {32'd0, d[63:32]};
      end
      default: word = d;
    endcase
    case (c[1:0])
      2'd1: tail = {56'd0, tail[7:0]};
      2'd2: tail = {48'd0, tail[15:0]};
      2'd3: tail = {40'd0, tail[23:0]};
      default: tail = '0;
    endcase
    topw = {({26'd0, r} << 24) | tail[31:0], 32'd0};
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    open_nxt = open_r;
    top_nxt = top_r;
    tail_lane_nxt = tail_lane_r;
    pend_fin_nxt = pend_fin_r;
    job_valid = 1'b0;
    job = '0;
    unique case (state_r)
      F_PASS: begin
        job.load = !open_r;
        job.lane = pos_r;
        job_valid = acc;
        if (acc) begin
          open_nxt = 1'b1;
          if (!in_item.last_word) begin
            job.msg = d;
            pos_nxt = pos_r + 2'd1;
          end else if (pos_r == 2'd3 && c == 4'd8) begin
            job.msg = d;
            top_nxt = '0;
            tail_lane_nxt = 2'd0;
            state_nxt = F_TAIL;
          end else if (pos_r == 2'd3) begin
            job.msg = word | topw;
            job.fin = 1'b1;
            open_nxt = 1'b0;
            pos_nxt = 2'd0;
          end else begin
            job.msg = word;
            top_nxt = topw;
            tail_lane_nxt = pos_r + 2'd1;
            state_nxt = F_TAIL;
          end
        end
      end
      F_TAIL: begin
        job_valid = 1'b1;
        job.lane = tail_lane_r;
        job.msg = (tail_lane_r == 2'd3) ? top_r : 64'd0;
        job.fin = (tail_lane_r == 2'd3);
        if (job_ready) begin
          tail_lane_nxt = tail_lane_r + 2'd1;
          if (tail_lane_r == 2'd3) begin
            state_nxt = F_PASS;
            open_nxt = 1'b0;
            pos_nxt = 2'd0;
          end
        end
      end
      default: state_nxt = F_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_PASS;
      pos_r <= '0;
      open_r <= 1'b0;
      pend_fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      open_r <= open_nxt;
      pend_fin_r <= pend_fin_nxt;
    end
    top_r <= top_nxt;
    tail_lane_r <= tail_lane_nxt;
  end

  `include "sip_tree_hash_four_lane_top_macros.svh"
  `STH_ASSERT_IMP(a_tail_no_accept, state_r == F_TAIL, in_full)
  `STH_ASSERT_NXT(a_fin_closes, job_valid && job_ready && job.fin, !open_r && pos_r == 2'd0)
  `STH_ASSERT_IMP(a_no_pend, 1'b1, !pend_fin_r)
endmodule

// File: rtl/core/sth_queue.sv
`timescale 1ns / 1ps
module sth_queue #(
  parameter int DEPTH = sth_pkg::QUEUE_DEPTH,
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          wr, rd;

  assign wr_ready = cnt_r != DEPTH[AW:0];
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// File: rtl/core/sth_back.sv
`timescale 1ns / 1ps
module sth_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [3:0][63:0]   keys,
  input  logic               job_valid,
  output logic               job_ready,
  input  sth_pkg::job_t      job,
  output logic               out_empty,
  input  logic               out_pop,
  output sth_pkg::out_item_t out_item
);
  import sth_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RND  = 4'b0010,
    B_FIN  = 4'b0100,
    B_HOLD = 4'b1000
  } bstate_t;

  bstate_t      state_r, state_nxt;
  lane_vec_t    lanes_r [4];
  lane_vec_t    lanes_nxt [4];
  lane_vec_t    cur, rnd, ld;
  logic [1:0]   lane_r, fl_r;
  logic [63:0]  msg_r, k;
  logic [1:0]   cnt_r;
  logic         fin_r, take;
  out_item_t    res_r;
  logic         res_v_r;
  logic [63:0]  h;

  assign out_empty = !res_v_r;
  assign out_item = res_r;
  assign job_ready = (state_r == B_IDLE) && !(job.fin && res_v_r && !out_pop);
  assign take = job_valid && job_ready;
  assign cur = (state_r == B_FIN) ? lanes_r[fl_r] : lanes_r[lane_r];
  assign rnd = arx_round(cur);
  assign h = rnd[0] ^ rnd[1] ^ rnd[2] ^ rnd[3];

  always_comb begin
    k = keys[job.lane] ^ {61'd0, 1'b1, job.lane};
    ld = job.load ? lane_vec_t'({INIT_C3 ^ k, INIT_C2 ^ k, INIT_C1 ^ k, INIT_C0 ^ k})
                  : lanes_r[job.lane];
    ld[3] = ld[3] ^ job.msg;
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (take) state_nxt = B_RND;
      B_RND: if (cnt_r == 2'd1) state_nxt = fin_r ? B_FIN : B_IDLE;
      B_FIN: if (cnt_r == 2'd3 && fl_r == 2'd3) state_nxt = B_IDLE;
      B_HOLD: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
    for (int l = 0; l < 4; l++) lanes_nxt[l] = lanes_r[l];
    unique case (state_r)
      B_IDLE: if (take) begin
        // load on message start: all lanes from keys
        if (job.load) begin
          for (int l = 0; l < 4; l++) begin
            lanes_nxt[l] = lane_vec_t'({INIT_C3 ^ keys[l] ^ 64'(4 + l),
                                        INIT_C2 ^ keys[l] ^ 64'(4 + l),
                                        INIT_C1 ^ keys[l] ^ 64'(4 + l),
                                        INIT_C0 ^ keys[l] ^ 64'(4 + l)});
          end
        end
        lanes_nxt[job.lane] = ld;
      end
      B_RND: begin
        lanes_nxt[lane_r] = rnd;
        if (cnt_r == 2'd1) begin
          lanes_nxt[lane_r][0] = rnd[0] ^ msg_r;
          if (fin_r) lanes_nxt[0][2] = lanes_nxt[0][2] ^ FINAL_MIX;
        end
      end
      B_FIN: begin
        lanes_nxt[fl_r] = rnd;
        if (cnt_r == 2'd3 && fl_r != 2'd3)
          lanes_nxt[fl_r + 2'd1][2] = lanes_r[fl_r + 2'd1][2] ^ FINAL_MIX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      res_v_r <= 1'b0;
      cnt_r <= '0;
      fl_r <= '0;
    end else begin
      state_r <= state_nxt;
      res_v_r <= (res_v_r && !out_pop) ||
                 (state_r == B_FIN && cnt_r == 2'd3 && fl_r == 2'd3);
      unique case (state_r)
        B_IDLE: if (take) begin
          cnt_r <= '0;
          fl_r <= '0;
        end
        B_RND: cnt_r <= (cnt_r == 2'd1) ? 2'd0 : cnt_r + 2'd1;
        B_FIN: begin
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) fl_r <= fl_r + 2'd1;
        end
        default: ;
      endcase
    end
    for (int l = 0; l < 4; l++) lanes_r[l] <= lanes_nxt[l];
    unique case (state_r)
      B_IDLE: if (take) begin
        lane_r <= job.lane;
        msg_r <= job.msg;
        fin_r <= job.fin;
      end
      B_FIN: begin
        if (cnt_r == 2'd3) begin
          unique case (fl_r)
            2'd0: res_r.lane_hash_0 <= h;
            2'd1: res_r.lane_hash_1 <= h;
            2'd2: res_r.lane_hash_2 <= h;
            default: res_r.lane_hash_3 <= h;
          endcase
        end
      end
      default: ;
    endcase
  end

  `include "sip_tree_hash_four_lane_top_macros.svh"
  `STH_ASSERT_IMP(a_busy_stall, state_r != B_IDLE, !job_ready)
  `STH_ASSERT_NXT(a_fin_result, state_r == B_FIN && cnt_r == 2'd3 && fl_r == 2'd3, res_v_r)
  `STH_ASSERT_IMP(a_no_hold, 1'b1, state_r != B_HOLD)
endmodule

// File: bench/tb_sip_tree_hash_four_lane_top.sv
`timescale 1ns / 1ps
module tb_sip_tree_hash_four_lane_top;
  import sth_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;

  class hash_scoreboard;
    logic [63:0] keys [4];
    logic [63:0] lanes [4][4];
    logic [1:0] position;
    bit open;
    out_item_t digests [$];
    int errors;

    function void clear();
      for (int i = 0; i < 4; i++) keys[i] = '0;
      position = '0;
      open = 0;
      errors = 0;
    endfunction

    function void mix(int l, int rounds);
      logic [63:0] a, b, c, d;
      a = lanes[l][0]; b = lanes[l][1]; c = lanes[l][2]; d = lanes[l][3];
      for (int i = 0; i < rounds; i++) begin
        a = a + b;
        c = c + d;
        b = {b[50:0], b[63:51]} ^ a;
        d = {d[47:0], d[63:48]} ^ c;
        a = {a[31:0], a[63:32]};
        c = c + b;
        a = a + d;
        b = {b[46:0], b[63:47]} ^ c;
        d = {d[42:0], d[63:43]} ^ a;
        c = {c[31:0], c[63:32]};
      end
      lanes[l][0] = a; lanes[l][1] = b; lanes[l][2] = c; lanes[l][3] = d;
    endfunction

    function void absorb(int l, logic [63:0] m);
      lanes[l][3] ^= m;
      mix(l, 2);
      lanes[l][0] ^= m;
    endfunction

    function void note_word(in_item_t it);
      logic [63:0] k, keep_word, tail, top;
      int c, pos, r, keep, tail_n;
      out_item_t h;
      logic [63:0] fin [4];
      if (!open) begin
        for (int l = 0; l < 4; l++) begin
          k = keys[l] ^ 64'(4 | l);
          lanes[l][0] = INIT_C0 ^ k;
          lanes[l][1] = INIT_C1 ^ k;
          lanes[l][2] = INIT_C2 ^ k;
          lanes[l][3] = INIT_C3 ^ k;
        end
        position = '0;
        open = 1;
      end
      pos = position;
      if (!it.last_word) begin
        absorb(pos, it.data_word);
        position = position + 2'd1;
        return;
      end
      c = (it.byte_count > 8) ? 8 : it.byte_count;
      if (pos == 3 && c == 8) begin
        absorb(3, it.data_word);
        for (int l = 0; l < 4; l++) absorb(l, '0);
      end else begin
        r = pos * 8 + c;
        keep = c & ~3;
        tail_n = c & 3;
        keep_word = (keep >= 8) ? it.data_word
                                : it.data_word & ((64'd1 << (keep * 8)) - 64'd1);
        tail = '0;
        if (tail_n != 0)
          tail = (it.data_word >> (keep * 8)) & ((64'd1 << (tail_n * 8)) - 64'd1);
        top = (((64'(r) << 24) | tail) & 64'hFFFF_FFFF) << 32;
        if (pos == 3) begin
          absorb(3, keep_word | top);
        end else begin
          absorb(pos, keep_word);
          for (int l = pos + 1; l < 3; l++) absorb(l, '0);
          absorb(3, top);
        end
      end
      for (int l = 0; l < 4; l++) begin
        lanes[l][2] ^= FINAL_MIX;
        mix(l, 4);
        fin[l] = lanes[l][0] ^ lanes[l][1] ^ lanes[l][2] ^ lanes[l][3];
      end
      h.lane_hash_0 = fin[0];
      h.lane_hash_1 = fin[1];
      h.lane_hash_2 = fin[2];
      h.lane_hash_3 = fin[3];
      digests.push_back(h);
      open = 0;
      position = '0;
    endfunction

    function void check_digest(out_item_t got);
      out_item_t want;
      if (digests.size() == 0) begin
        $error("unexpected item %h", got);
        errors++;
        return;
      end
      want = digests.pop_front();
      if (got.lane_hash_0 !== want.lane_hash_0) begin
        $error("lane_hash_0 exp %h got %h", want.lane_hash_0, got.lane_hash_0);
        errors++;
      end
      if (got.lane_hash_1 !== want.lane_hash_1) begin
        $error("lane_hash_1 exp %h got %h", want.lane_hash_1, got.lane_hash_1);
        errors++;
      end
      if (got.lane_hash_2 !== want.lane_hash_2) begin
        $error("lane_hash_2 exp %h got %h", want.lane_hash_2, got.lane_hash_2);
        errors++;
      end
      if (got.lane_hash_3 !== want.lane_hash_3) begin
        $error("lane_hash_3 exp %h got %h", want.lane_hash_3, got.lane_hash_3);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 0;
  out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  hash_scoreboard sb;
  int cycles = 0;
  bit calm = 0;

  always #5 clk = ~clk;

  sip_tree_hash_four_lane_top dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_digest(out_item);
  end

  always @(negedge clk) begin
    pop <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_key(logic [1:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.keys[idx] = val;
    @(negedge clk);
  endtask

  task automatic send_word(logic [63:0] d, logic [3:0] n, logic lst);
    in_item_t it;
    while (!calm && $urandom_range(99) < 8) begin
      in_push <= 0;
      @(negedge clk);
    end
    it.data_word = d;
    it.byte_count = n;
    it.last_word = lst;
    in_item <= it;
    in_push <= 1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_word(it);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_push <= 0;
    while (sb.digests.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_message(int max_words, output int words);
    int n;
    n = $urandom_range(max_words, 1);
    for (int i = 1; i < n; i++)
      send_word(rand64(), ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8, 0);
    send_word(rand64(), ($urandom_range(5) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(8, 1)), 1);
    words = n;
  endtask

  task automatic key_phase(logic [63:0] k0, logic [63:0] k1,
                           logic [63:0] k2, logic [63:0] k3);
    wait_idle();
    write_key(CFG_KEY_0, k0);
    write_key(CFG_KEY_1, k1);
    write_key(CFG_KEY_2, k2);
    write_key(CFG_KEY_3, k3);
    cfg_valid <= 0;
  endtask

  initial begin
    int sent;
    int n_words;
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: every final lane position with an odd byte count, then extremes
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < p; i++) send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 0);
      send_word(64'h0807_0605_0403_0201, 4'(p * 2 + 1), 1);
    end
    send_word('0, 4'd3, 0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1);
    send_word(64'h1122_3344_5566_7788, 4'd0, 1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1);
    send_word(64'hA5A5_A5A5_5A5A_5A5A, 4'd4, 1);
    for (int i = 0; i < 3; i++) send_word(rand64(), 4'd8, 0);
    send_word(rand64(), 4'd8, 1);

    key_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(64'h0, 4'd8, 0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1);

    sent = 21;
    for (int ph = 0; ph < 6; ph++) begin
      key_phase(rand64(), rand64(), rand64(), rand64());
      calm = (ph == 2);
      while (sent < 20 + (ph + 1) * 295) begin
        random_message(12, n_words);
        sent = sent + n_words;
        if ($urandom_range(40) == 0) wait_idle();
      end
    end
    calm = 0;
    key_phase('0, '0, '0, '0);
    repeat (20) random_message(9, n_words);

    wait_idle();
    if (sb.errors == 0 && sb.digests.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
